### rtl/core/step_deadline_watchdog_core_macros.svh
// ----------------------------------------------------------------------------
// Step deadline watchdog assertion macros
// Concurrent checks on the aclk domain, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef STEP_DEADLINE_WATCHDOG_CORE_MACROS_SVH
`define STEP_DEADLINE_WATCHDOG_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SDW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sdw_pkg.sv
// ----------------------------------------------------------------------------
// Step deadline watchdog package
// Shared constants, command codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package sdw_pkg;

    localparam int STEPS    = 8;
    localparam int IDX_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 32;
    localparam int SIDX_W   = 4;
    localparam int FAIL_W   = 3;
    localparam int PERIOD_W = 16;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Running (k+1)*period stays below 16 * 2^16.
    localparam int PROD_W      = PERIOD_W + 4;
    localparam int RECIP_SHIFT = PROD_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(STEPS) - 64'd1) / 64'(STEPS));

    localparam logic [SIDX_W:0] STEPS_LIM = (SIDX_W + 1)'(STEPS);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic                REG_PERIOD   = 1'b0;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [FAIL_W-1:0]   fail_t;
    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [PERIOD_W-1:0] period_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ARM    = 2'd0,
        FUNC_RECORD = 2'd1,
        FUNC_CHECK  = 2'd2
    } func_t;

    typedef struct packed {
        logic load;
        logic arm_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic arm_req;
        logic last_step;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/step_deadline_watchdog_core.sv
// ----------------------------------------------------------------------------
// Step deadline watchdog core
// Checkpoint watchdog for a periodic cycle split into equal steps.
// ----------------------------------------------------------------------------
// Each command beat returns exactly one result beat. Record and check are
// accepted in idle, then evaluated into the output register in the response
// state; arm first walks the STEPS step deadlines in the arm state with the
// single reciprocal multiplier, one step deadline per cycle. The output
// register decouples the result side; a stalled result holds until taken,
// and a new command is accepted as soon as the controller is back in idle.
// The period register is written over the APB-style port at byte address 0.
`default_nettype none

`include "step_deadline_watchdog_core_macros.svh"

module step_deadline_watchdog_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [sdw_pkg::FUNC_W-1:0]   s_func,
    input  wire logic [sdw_pkg::TIME_W-1:0]   s_time_ms,
    input  wire logic [sdw_pkg::SIDX_W-1:0]   s_step_index,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_timeout,
    output logic [sdw_pkg::FAIL_W-1:0]        m_failing_step,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sdw_pkg::DATA_W-1:0]   pwdata,
    output logic      [sdw_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    sdw_pkg::period_t  period_ms;
    sdw_pkg::dp_cmd_t  cmd;
    sdw_pkg::dp_stat_t stat;

    sdw_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .period_ms (period_ms)
    );

    sdw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sdw_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_func         (s_func),
        .s_time_ms      (s_time_ms),
        .s_step_index   (s_step_index),
        .period_ms      (period_ms),
        .m_timeout      (m_timeout),
        .m_failing_step (m_failing_step)
    );

    `SDW_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second beat taken in flight")
    `SDW_ASSERT_SAME(a_load_slot_free, cmd.out_load, !m_valid || m_ready, "result overwritten")
    `SDW_ASSERT_SAME(a_fail_zero, m_valid && !m_timeout, m_failing_step == '0, "stray step index")

endmodule

`default_nettype wire

### rtl/core/sdw_regs.sv
// ----------------------------------------------------------------------------
// Step deadline watchdog configuration registers
// APB-style register file holding the cycle period.
// ----------------------------------------------------------------------------
`default_nettype none

module sdw_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sdw_pkg::DATA_W-1:0]   pwdata,
    output logic      [sdw_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output sdw_pkg::period_t                  period_ms
);

    sdw_pkg::period_t period_reg;
    sdw_pkg::period_t period_next;
    logic             sel_period;

    assign sel_period = (paddr[sdw_pkg::ADDR_W-1] == sdw_pkg::REG_PERIOD);

    always_comb begin
        period_next = period_reg;
        if (psel && penable && pwrite && sel_period) begin
            period_next = pwdata[sdw_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= sdw_pkg::PERIOD_RESET;
        end else begin
            period_reg <= period_next;
        end
    end

    assign prdata    = sel_period ? sdw_pkg::DATA_W'(period_reg) : '0;
    assign pready    = 1'b1;
    assign period_ms = period_reg;

endmodule

`default_nettype wire

### rtl/core/sdw_ctrl.sv
// ----------------------------------------------------------------------------
// Step deadline watchdog controller
// Sequences accept, deadline arming and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sdw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire sdw_pkg::dp_stat_t stat,
    output sdw_pkg::dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ARM  = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.arm_req ? ST_ARM : ST_RESP;
                end
            end
            ST_ARM: begin
                cmd.arm_step = 1'b1;
                if (stat.last_step) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/core/sdw_dp.sv
// ----------------------------------------------------------------------------
// Step deadline watchdog datapath
// Deadline and completion store, reciprocal offset unit, overdue search.
// ----------------------------------------------------------------------------
`default_nettype none

module sdw_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sdw_pkg::dp_cmd_t            cmd,
    output sdw_pkg::dp_stat_t                stat,
    input  wire logic [sdw_pkg::FUNC_W-1:0]  s_func,
    input  wire logic [sdw_pkg::TIME_W-1:0]  s_time_ms,
    input  wire logic [sdw_pkg::SIDX_W-1:0]  s_step_index,
    input  wire sdw_pkg::period_t            period_ms,
    output logic                             m_timeout,
    output logic [sdw_pkg::FAIL_W-1:0]       m_failing_step
);

    logic [sdw_pkg::FUNC_W-1:0]  func_reg;
    sdw_pkg::time_t              time_reg;

    logic [sdw_pkg::PROD_W-1:0]  prod_reg;
    sdw_pkg::idx_t               k_reg;
    sdw_pkg::period_t            off_reg;
    sdw_pkg::period_t            off_next;
    sdw_pkg::idx_t               wk_reg;
    logic                        wen_reg;

    logic [sdw_pkg::STEPS-1:0]   done_reg;
    sdw_pkg::time_t              dl_reg [sdw_pkg::STEPS];

    logic                        timeout_reg;
    logic                        timeout_next;
    sdw_pkg::fail_t              fail_reg;
    sdw_pkg::fail_t              fail_next;

    logic [sdw_pkg::PROD_W+sdw_pkg::RECIP_W-1:0] recip_prod;
    logic                        rec_hit;
    logic                        hit_any;
    sdw_pkg::fail_t              hit_idx;

    assign stat.arm_req   = (s_func == sdw_pkg::FUNC_ARM);
    assign stat.last_step = (k_reg == sdw_pkg::idx_t'(sdw_pkg::STEPS - 1));

    assign rec_hit = (s_func == sdw_pkg::FUNC_RECORD) &&
                     ({1'b0, s_step_index} < sdw_pkg::STEPS_LIM);

    assign recip_prod = prod_reg * sdw_pkg::RECIP_MUL;
    assign off_next   = recip_prod[sdw_pkg::RECIP_SHIFT +: sdw_pkg::PERIOD_W];

    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = sdw_pkg::STEPS - 1; k >= 0; k--) begin
            if (!done_reg[k] && (time_reg > dl_reg[k])) begin
                hit_any = 1'b1;
                hit_idx = sdw_pkg::fail_t'(k);
            end
        end
        timeout_next = (func_reg == sdw_pkg::FUNC_CHECK) && hit_any;
        fail_next    = timeout_next ? hit_idx : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            time_reg <= s_time_ms;
        end
        if (cmd.arm_step) begin
            off_reg <= off_next;
            wk_reg  <= k_reg;
        end
        if (cmd.out_load) begin
            timeout_reg <= timeout_next;
            fail_reg    <= fail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg <= '0;
            k_reg    <= '0;
            wen_reg  <= 1'b0;
            done_reg <= '0;
            dl_reg   <= '{default: '0};
        end else begin
            wen_reg <= cmd.arm_step;
            if (cmd.load && stat.arm_req) begin
                done_reg <= '0;
                prod_reg <= sdw_pkg::PROD_W'(period_ms);
                k_reg    <= '0;
            end
            if (cmd.load && rec_hit) begin
                done_reg[s_step_index[sdw_pkg::IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.arm_step) begin
                prod_reg <= prod_reg + sdw_pkg::PROD_W'(period_ms);
                k_reg    <= k_reg + 1'b1;
            end
            if (wen_reg) begin
                dl_reg[wk_reg] <= time_reg + sdw_pkg::TIME_W'(off_reg);
            end
        end
    end

    assign m_timeout      = timeout_reg;
    assign m_failing_step = fail_reg;

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Step deadline watchdog testbench
// Drives arm, record and check beats with directed and random traffic, over
// several period settings and idle patterns. Each result is checked against
// an in-bench deadline tracker that keeps its own steps and deadlines.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sdw_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [sdw_pkg::ADDR_W-1:0] PERIOD_ADDR =
        sdw_pkg::ADDR_W'(4 * int'(sdw_pkg::REG_PERIOD));
    localparam int PHASES = 8;
    localparam int PHASE_BEATS = 180;

    typedef struct packed {
        logic           timeout;
        sdw_pkg::fail_t step;
    } verdict_t;

    class deadline_tracker;
        sdw_pkg::period_t period;
        bit               done [sdw_pkg::STEPS];
        sdw_pkg::time_t   deadline [sdw_pkg::STEPS];
        verdict_t         expected_verdicts [$];
        int               errors;

        function new();
            period = sdw_pkg::PERIOD_RESET;
            errors = 0;
            for (int k = 0; k < sdw_pkg::STEPS; k++) begin
                done[k] = 1'b0;
                deadline[k] = '0;
            end
        endfunction

        function void note_command(logic [sdw_pkg::FUNC_W-1:0] f, sdw_pkg::time_t stamp,
                                   logic [sdw_pkg::SIDX_W-1:0] idx);
            verdict_t v;
            logic [31:0] offset;
            v = '0;
            case (f)
                sdw_pkg::FUNC_ARM: begin
                    for (int k = 0; k < sdw_pkg::STEPS; k++) begin
                        offset = (32'(k + 1) * 32'(period)) / 32'(sdw_pkg::STEPS);
                        done[k] = 1'b0;
                        deadline[k] = stamp + offset;
                    end
                end
                sdw_pkg::FUNC_RECORD: begin
                    if (int'(idx) < sdw_pkg::STEPS) begin
                        done[idx] = 1'b1;
                    end
                end
                sdw_pkg::FUNC_CHECK: begin
                    for (int k = 0; k < sdw_pkg::STEPS; k++) begin
                        if (!v.timeout && !done[k] && stamp > deadline[k]) begin
                            v.timeout = 1'b1;
                            v.step = sdw_pkg::fail_t'(k);
                        end
                    end
                end
                default: ;
            endcase
            expected_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic timeout, sdw_pkg::fail_t step);
            verdict_t v;
            if (expected_verdicts.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("result beat with no command pending: timeout %0b step %0d",
                             timeout, step);
                end
                return;
            end
            v = expected_verdicts.pop_front();
            if (timeout !== v.timeout || step !== v.step) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: timeout exp %0b act %0b, failing_step exp %0d act %0d",
                             v.timeout, timeout, v.step, step);
                end
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [sdw_pkg::FUNC_W-1:0]    s_func;
    logic [sdw_pkg::TIME_W-1:0]    s_time_ms;
    logic [sdw_pkg::SIDX_W-1:0]    s_step_index;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_timeout;
    logic [sdw_pkg::FAIL_W-1:0]    m_failing_step;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sdw_pkg::ADDR_W-1:0]    paddr;
    logic [sdw_pkg::DATA_W-1:0]    pwdata;
    logic [sdw_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    deadline_tracker watchdog;
    int send_idle;
    int recv_stall;

    step_deadline_watchdog_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_time_ms      (s_time_ms),
        .s_step_index   (s_step_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_timeout      (m_timeout),
        .m_failing_step (m_failing_step),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            watchdog.check_verdict(m_timeout, m_failing_step);
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_command(input logic [sdw_pkg::FUNC_W-1:0] f,
                                input sdw_pkg::time_t stamp,
                                input logic [sdw_pkg::SIDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_time_ms    <= stamp;
        s_step_index <= idx;
        do @(posedge aclk); while (!s_ready);
        watchdog.note_command(f, stamp, idx);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (watchdog.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_period(input sdw_pkg::period_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PERIOD_ADDR;
        pwdata  <= sdw_pkg::DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        watchdog.period = value;
    endtask

    task automatic run_directed();
        send_command(sdw_pkg::FUNC_CHECK, 32'd0, 4'd0);
        send_command(sdw_pkg::FUNC_CHECK, 32'd1, 4'd0);
        send_command(sdw_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 4'd15);
        send_command(FUNC_UNUSED, 32'hFFFF_FFFF, 4'd15);
        send_command(sdw_pkg::FUNC_ARM, 32'hFFFF_FFFF, 4'd0);
        send_command(sdw_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 4'd0);
        send_command(sdw_pkg::FUNC_ARM, 32'd1000, 4'd0);
        send_command(sdw_pkg::FUNC_RECORD, 32'd0, 4'd0);
        send_command(sdw_pkg::FUNC_RECORD, 32'd0, 4'd2);
        send_command(sdw_pkg::FUNC_RECORD, 32'd0, 4'd8);
        send_command(sdw_pkg::FUNC_RECORD, 32'hFFFF_FFFF, 4'd15);
        send_command(sdw_pkg::FUNC_CHECK, 32'd1012, 4'd0);
        send_command(sdw_pkg::FUNC_CHECK, 32'd1013, 4'd0);
        send_command(sdw_pkg::FUNC_CHECK, 32'd1026, 4'd0);
        for (int k = 1; k < sdw_pkg::STEPS - 1; k++) begin
            if (k != 2) begin
                send_command(sdw_pkg::FUNC_RECORD, 32'd0, sdw_pkg::SIDX_W'(k));
            end
        end
        send_command(sdw_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 4'd0);
        send_command(sdw_pkg::FUNC_RECORD, 32'd0, sdw_pkg::SIDX_W'(sdw_pkg::STEPS - 1));
        send_command(sdw_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 4'd0);
        send_command(sdw_pkg::FUNC_CHECK, 32'd0, 4'd0);
    endtask

    task automatic run_random(input int count);
        int n;
        int k;
        int burst;
        bit drained;
        sdw_pkg::time_t stamp;
        logic [sdw_pkg::SIDX_W-1:0] idx;
        n = 0;
        drained = 1'b0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_command(sdw_pkg::FUNC_W'($urandom_range(0, 3)), $urandom,
                             sdw_pkg::SIDX_W'($urandom_range(0, 15)));
                n++;
            end else begin
                case ($urandom_range(0, 7))
                    0: stamp = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                    1: stamp = $urandom_range(0, 100);
                    default: stamp = $urandom;
                endcase
                send_command(sdw_pkg::FUNC_ARM, stamp,
                             sdw_pkg::SIDX_W'($urandom_range(0, 15)));
                n++;
                burst = $urandom_range(3, 14);
                repeat (burst) begin
                    if ($urandom_range(0, 1) == 0) begin
                        if ($urandom_range(0, 9) == 0) begin
                            idx = sdw_pkg::SIDX_W'($urandom_range(sdw_pkg::STEPS, 15));
                        end else begin
                            idx = sdw_pkg::SIDX_W'($urandom_range(0, sdw_pkg::STEPS - 1));
                        end
                        send_command(sdw_pkg::FUNC_RECORD, $urandom, idx);
                    end else begin
                        k = $urandom_range(0, sdw_pkg::STEPS - 1);
                        case ($urandom_range(0, 5))
                            0: stamp = watchdog.deadline[k] - 1;
                            1: stamp = watchdog.deadline[k];
                            2: stamp = watchdog.deadline[k] + 1;
                            3: stamp = watchdog.deadline[k] + $urandom_range(0, 40);
                            4: stamp = watchdog.deadline[k] - $urandom_range(0, 40);
                            default: stamp = $urandom;
                        endcase
                        send_command(sdw_pkg::FUNC_CHECK, stamp,
                                     sdw_pkg::SIDX_W'($urandom_range(0, 15)));
                    end
                    n++;
                end
            end
            if (!drained && n >= count / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        sdw_pkg::period_t value;
        watchdog = new();
        send_idle    = 0;
        recv_stall   = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_func       <= sdw_pkg::FUNC_ARM;
        s_time_ms    <= '0;
        s_step_index <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 59; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 59; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: value = 16'd1;
                    2: value = 16'hFFFF;
                    3: value = 16'd0;
                    4: value = 16'd8;
                    5: value = 16'd7;
                    default: value = sdw_pkg::period_t'($urandom_range(2, 65534));
                endcase
                write_period(value);
            end
            run_random(PHASE_BEATS);
        end

        wait_drained();
        repeat (12) @(posedge aclk);
        if (watchdog.errors == 0 && watchdog.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/sdw_pkg.sv
rtl/core/sdw_regs.sv
rtl/core/sdw_ctrl.sv
rtl/core/sdw_dp.sv
rtl/core/step_deadline_watchdog_core.sv
sim/testbench.sv
